@@ rtl/dcdg_pkg.sv @@
package dcdg_pkg;

  localparam int unsigned PHASE_BITS      = 32;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SAMPLE_BITS     = 16;

  // Register fields are scaled to 2^32; align them to the phase width.
  localparam int unsigned REG_BITS  = 32;
  localparam int unsigned UP_SH     = (PHASE_BITS > REG_BITS) ? PHASE_BITS - REG_BITS : 0;
  localparam int unsigned DN_SH     = (PHASE_BITS < REG_BITS) ? REG_BITS - PHASE_BITS : 0;
  // Triangle and sawtooth work on at most the top 32 phase bits.
  localparam int unsigned WORK_BITS = PHASE_BITS - UP_SH;

  localparam int unsigned QTR_BITS  = SINE_TABLE_BITS - 2;
  localparam int unsigned QTR       = 1 << QTR_BITS;
  localparam int unsigned MAG_BITS  = SAMPLE_BITS - 1;
  localparam longint unsigned AMP   = (64'd1 << MAG_BITS) - 64'd1;

  localparam int unsigned STEP_BITS = 31;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [STEP_BITS-1:0] RESET_STEP = STEP_BITS'(97391139);

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [MAG_BITS-1:0]           mag_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [STEP_BITS-1:0]          step_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SHAPE   = CFG_IDX_W'(0),
    REG_LEFT_STEP    = CFG_IDX_W'(1),
    REG_RIGHT_STEP   = CFG_IDX_W'(2),
    REG_RIGHT_OFFSET = CFG_IDX_W'(3)
  } cfg_reg_e;

  typedef struct packed {
    logic s2;
    logic s3;
  } pipe_en_t;

  typedef mag_t sine_tab_t [QTR];

  // Quarter-wave sine entry, Q30 Horner series to x^11, rounded to AMP.
  function automatic mag_t sine_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x  = (HALF_PI_Q30 * k) / QTR;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s * AMP + (Q30_ONE >> 1)) >> 30;
    if (v > AMP) begin
      v = AMP;
    end
    return mag_t'(v);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k < QTR; k++) begin
      tab[k] = sine_entry(longint'(k));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  // Entry at a full quarter turn sits outside the table.
  localparam mag_t      SINE_TOP = sine_entry(longint'(QTR));

  function automatic phase_t align_reg(input logic [REG_BITS-1:0] v);
    logic [PHASE_BITS+REG_BITS-1:0] w;
    w = {{PHASE_BITS{1'b0}}, v};
    w = (w << UP_SH) >> DN_SH;
    return w[PHASE_BITS-1:0];
  endfunction

endpackage

@@ rtl/dcdg_shape.sv @@
module dcdg_shape (
  input  logic              clk_i,
  input  dcdg_pkg::pipe_en_t en_i,
  input  dcdg_pkg::wave_e   shape_i,
  input  dcdg_pkg::phase_t  phase_i,
  output dcdg_pkg::sample_t sample_o
);

  localparam int unsigned WB = dcdg_pkg::WORK_BITS;
  localparam int unsigned MB = dcdg_pkg::MAG_BITS;
  localparam int unsigned TB = dcdg_pkg::SINE_TABLE_BITS;
  localparam int unsigned QB = dcdg_pkg::QTR_BITS;

  localparam logic [WB:0]   FULL   = {1'b1, {WB{1'b0}}};
  localparam logic [WB+2:0] FULL_X = {3'b001, {WB{1'b0}}};
  localparam logic [QB:0]   QTR_A  = {1'b1, {QB{1'b0}}};

  logic [WB-1:0] u;
  logic [WB:0]   rest;
  logic [WB:0]   d;
  logic [WB+2:0] d4;
  logic [WB:0]   m;
  logic          neg;
  logic [WB+MB:0] prod;

  logic [TB-1:0] idx;
  logic [1:0]    quad;
  logic [QB-1:0] j;
  logic [QB:0]   addr;
  dcdg_pkg::mag_t sine_mag;

  logic           sine_q;
  logic           sine_neg_q;
  dcdg_pkg::mag_t sine_mag_q;
  logic           arith_neg_q;
  dcdg_pkg::mag_t arith_mag_q;

  logic           neg_sel;
  dcdg_pkg::mag_t mag_sel;
  dcdg_pkg::sample_t sample_d;
  dcdg_pkg::sample_t sample_q;

  // Triangle, sawtooth and square all reduce to +-(m * AMP) >> WB.
  always_comb begin
    u    = phase_i[dcdg_pkg::PHASE_BITS-1 -: WB];
    rest = FULL - {1'b0, u};
    d    = u[WB-1] ? rest : {1'b0, u};
    d4   = {d, 2'b00};
    case (shape_i)
      dcdg_pkg::WAVE_TRIANGLE: begin
        neg = (d4 < FULL_X);
        m   = neg ? (WB+1)'(FULL_X - d4) : (WB+1)'(d4 - FULL_X);
      end
      dcdg_pkg::WAVE_SAWTOOTH: begin
        neg = u[WB-1];
        m   = u[WB-1] ? {rest[WB-1:0], 1'b0} : {u, 1'b0};
      end
      default: begin
        neg = u[WB-1];
        m   = FULL;
      end
    endcase
    // AMP is 2^MB - 1, so the product is a shift and a subtract
    prod = {m, {MB{1'b0}}} - {{MB{1'b0}}, m};
  end

  // Quarter-wave lookup: odd quadrants mirror, upper half negates.
  always_comb begin
    idx  = phase_i[dcdg_pkg::PHASE_BITS-1 -: TB];
    quad = idx[TB-1 -: 2];
    j    = idx[QB-1:0];
    addr = quad[0] ? (QTR_A - {1'b0, j}) : {1'b0, j};
    sine_mag = addr[QB] ? dcdg_pkg::SINE_TOP : dcdg_pkg::SINE_TAB[addr[QB-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sine_q      <= (shape_i == dcdg_pkg::WAVE_SINE);
      sine_neg_q  <= quad[1];
      sine_mag_q  <= sine_mag;
      arith_neg_q <= neg;
      arith_mag_q <= prod[WB+MB-1:WB];
    end
  end

  always_comb begin
    neg_sel  = sine_q ? sine_neg_q : arith_neg_q;
    mag_sel  = sine_q ? sine_mag_q : arith_mag_q;
    sample_d = neg_sel ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

@@ rtl/dual_channel_dds_waveform_gen.sv @@
// Stereo DDS generator: every accepted input transaction with sample_tick set yields one
// left/right sample pair from two 32-bit phase accumulators (right channel reads its
// accumulator plus right_offset), shaped as sine, triangle, sawtooth or square at
// +-32767. A transaction with sample_tick clear yields nothing and holds the phases. Throughput
// is one pair per clock while out_ready_i is high; each pair passes the phase register, the
// lookup/multiply and output registers to out_valid_o; an output stall holds it.
// Configuration writes are taken every cycle and must happen while the block is idle;
// writes to unknown indexes are ignored.
module dual_channel_dds_waveform_gen (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_sample_tick_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dcdg_pkg::SAMPLE_BITS-1:0] out_left_pcm_o,
  output logic signed [dcdg_pkg::SAMPLE_BITS-1:0] out_right_pcm_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcdg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dcdg_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  dcdg_pkg::wave_e  wave_q;
  dcdg_pkg::step_t  lstep_q;
  dcdg_pkg::step_t  rstep_q;
  logic [dcdg_pkg::REG_BITS-1:0] roffs_q;

  dcdg_pkg::phase_t lacc_q, lacc_d;
  dcdg_pkg::phase_t racc_q, racc_d;
  dcdg_pkg::phase_t lph_q;
  dcdg_pkg::phase_t rph_q;

  logic vld1_q, vld2_q, vld3_q;
  logic rdy1, rdy2, rdy3;
  logic tick_acc;
  dcdg_pkg::pipe_en_t en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= dcdg_pkg::WAVE_SINE;
      lstep_q <= dcdg_pkg::RESET_STEP;
      rstep_q <= dcdg_pkg::RESET_STEP;
      roffs_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dcdg_pkg::REG_WAVE_SHAPE:   wave_q  <= dcdg_pkg::wave_e'(cfg_data_i[1:0]);
        dcdg_pkg::REG_LEFT_STEP:    lstep_q <= cfg_data_i[dcdg_pkg::STEP_BITS-1:0];
        dcdg_pkg::REG_RIGHT_STEP:   rstep_q <= cfg_data_i[dcdg_pkg::STEP_BITS-1:0];
        dcdg_pkg::REG_RIGHT_OFFSET: roffs_q <= cfg_data_i[dcdg_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves when it is empty or the next one can take its data.
  assign rdy3       = !vld3_q || out_ready_i;
  assign rdy2       = !vld2_q || rdy3;
  assign rdy1       = !vld1_q || rdy2;
  assign in_ready_o = rdy1;
  assign tick_acc   = in_valid_i && rdy1 && in_sample_tick_i;
  assign en.s2      = rdy2;
  assign en.s3      = rdy3;

  assign lacc_d = lacc_q + dcdg_pkg::align_reg({1'b0, lstep_q});
  assign racc_d = racc_q + dcdg_pkg::align_reg({1'b0, rstep_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lacc_q <= '0;
      racc_q <= '0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (tick_acc) begin
        lacc_q <= lacc_d;
        racc_q <= racc_d;
      end
      if (rdy1) begin
        vld1_q <= in_valid_i && in_sample_tick_i;
      end
      if (rdy2) begin
        vld2_q <= vld1_q;
      end
      if (rdy3) begin
        vld3_q <= vld2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      lph_q <= lacc_q;
      rph_q <= racc_q + dcdg_pkg::align_reg(roffs_q);
    end
  end

  dcdg_shape u_left (
    .clk_i    (clk_i),
    .en_i     (en),
    .shape_i  (wave_q),
    .phase_i  (lph_q),
    .sample_o (out_left_pcm_o)
  );

  dcdg_shape u_right (
    .clk_i    (clk_i),
    .en_i     (en),
    .shape_i  (wave_q),
    .phase_i  (rph_q),
    .sample_o (out_right_pcm_o)
  );

  assign out_valid_o = vld3_q;

endmodule

@@ rtl/dcdg_checker.sv @@
module dcdg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                in_sample_tick_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [dcdg_pkg::SAMPLE_BITS-1:0] out_left_pcm_o,
  input logic signed [dcdg_pkg::SAMPLE_BITS-1:0] out_right_pcm_o
);

  localparam logic [dcdg_pkg::SAMPLE_BITS-1:0] MOST_NEG =
    {1'b1, {(dcdg_pkg::SAMPLE_BITS-1){1'b0}}};

  // Samples are symmetric around zero; the most negative code never shows up.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_left_pcm_o != MOST_NEG) && (out_right_pcm_o != MOST_NEG))
    else $error("sample outside +-AMP");

  // After a gap, each new result traces back through vld1_q, vld2_q and vld3_q to its tick.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_sample_tick_i, 3))
    else $error("result without matching tick");

  // With the output empty the whole pipe can take input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_left_pcm_o) && $stable(out_right_pcm_o))
    else $error("stalled result changed");

endmodule

bind dual_channel_dds_waveform_gen dcdg_checker u_dcdg_checker (.*);
